// File: design/ultrasonic_echo_ranger_unit_assert.svh
// Assertion macros used by the checker of the ultrasonic echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UER_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ultrasonic_echo_ranger_unit: check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UER_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ultrasonic_echo_ranger_unit: check failed");

`endif

// File: design/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types and fixed constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  localparam int TRIG_W     = 10;
  localparam int GAP_W      = 20;
  localparam int DIST_W     = 19;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TRIG_W-1:0] TRIG_RESET = TRIG_W'(20);
  localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(100000);
  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

  // Echo round trip time per centimetre, in microseconds.
  localparam int US_PER_CM = 58;
  // Four fractional bits in the distance result.
  localparam int FRAC_BITS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_US = 1'b0,
    CFG_GAP_US     = 1'b1
  } cfg_idx_e;

  // Per-tick output flags carried down the result pipeline.
  typedef struct packed {
    logic trig;
    logic busy;
    logic rvalid;
  } tick_flags_t;

endpackage

`default_nettype wire

// File: design/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Pulse-echo range finder: fires trigger pulses, times the echo pulses,
// and reports the averaged distance in Q4 centimetres.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Beat contents
//  in       sink       in_valid_i/in_stall_o   echo_level_i, start_req_i
//  out      source     out_valid_o/out_stall_i trigger_out_o, busy_res_o,
//                                              result_valid_o, distance_q4_o
//  cfg      sink       cfg_we_i                cfg_idx_i, cfg_data_i
//
//  One input beat is accepted per cycle while in_stall_o is low; each gives exactly one output beat.
//  The stages are the sequencer update, the reciprocal multiply, and the
//  remainder correction into the output register.
//  The three stages fill bubbles, so the input keeps flowing while a beat
//  waits on a stalled output until all three stages hold a beat.
//  Reset empties the pipeline, returns the sequencer to idle and loads the
//  register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_unit
  import uer_pkg::*;
#(
  parameter int SAMPLES    = 5,
  parameter int COUNT_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  echo_level_i,
  input  wire logic                  start_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       trigger_out_o,
  output logic                       busy_res_o,
  output logic                       result_valid_o,
  output logic [DIST_W-1:0]          distance_q4_o
);

  localparam int TICK_W = (COUNT_BITS > GAP_W) ? COUNT_BITS : GAP_W;
  localparam int SUM_W  = COUNT_BITS + $clog2(SAMPLES);
  localparam int DIV    = US_PER_CM * SAMPLES;
  // Scaled numerator sum * 16 fits in K bits.
  localparam int K      = SUM_W + FRAC_BITS;
  localparam longint unsigned RECIP = (64'd1 << K) / DIV;
  localparam int M_W    = K - $clog2(DIV) + 1;
  localparam int Q_W    = M_W;
  localparam int P_W    = SUM_W + M_W;
  localparam int QX_W   = (Q_W + 1 > DIST_W) ? Q_W + 1 : DIST_W + 1;
  localparam int SHOT_W = 4;

  localparam logic [TICK_W-1:0] COUNT_MAX = TICK_W'({COUNT_BITS{1'b1}});
  localparam logic [M_W-1:0]    RECIP_M   = M_W'(RECIP);
  localparam logic [K-1:0]      DIV_K     = K'(DIV);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_MEAS,
    PH_GAP
  } phase_e;

  // Configuration registers.
  logic [TRIG_W-1:0] trigger_us_q;
  logic [GAP_W-1:0]  gap_us_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_us_q <= TRIG_RESET;
      gap_us_q     <= GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TRIGGER_US: trigger_us_q <= cfg_data_i[TRIG_W-1:0];
        CFG_GAP_US:     gap_us_q     <= cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline stage occupancy and bubble-filling advance.
  logic s1_v_q, s2_v_q, s3_v_q;
  logic ld1, ld2, ld3, in_acc;

  assign ld3        = !s3_v_q || !out_stall_i;
  assign ld2        = !s2_v_q || ld3;
  assign ld1        = !s1_v_q || ld2;
  assign in_stall_o = !ld1;
  assign in_acc     = in_valid_i && ld1;

  // Sequencer, advanced once per accepted tick.
  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SHOT_W-1:0] shots_q, shots_d;
  tick_flags_t       flags_d;

  always_comb begin
    phase_d       = phase_q;
    tick_d        = tick_q;
    sum_d         = sum_q;
    shots_d       = shots_q;
    flags_d       = '0;
    case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          sum_d        = '0;
          shots_d      = '0;
          tick_d       = TICK_W'(1);
          phase_d      = PH_TRIG;
          flags_d.trig = 1'b1;
        end
      end
      PH_TRIG: begin
        if (tick_q >= TICK_W'(trigger_us_q)) begin
          tick_d  = '0;
          phase_d = PH_WAIT;
        end else begin
          tick_d       = tick_q + TICK_W'(1);
          flags_d.trig = 1'b1;
        end
      end
      PH_WAIT: begin
        if (echo_level_i) begin
          tick_d  = TICK_W'(1);
          phase_d = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo_level_i) begin
          if (tick_q < COUNT_MAX) begin
            tick_d = tick_q + TICK_W'(1);
          end
        end else begin
          sum_d   = sum_q + SUM_W'(tick_q[COUNT_BITS-1:0]);
          shots_d = shots_q + SHOT_W'(1);
          tick_d  = '0;
          phase_d = PH_GAP;
        end
      end
      PH_GAP: begin
        if (tick_q >= TICK_W'(gap_us_q)) begin
          if (shots_q >= SHOT_W'(SAMPLES)) begin
            flags_d.rvalid = 1'b1;
            tick_d         = '0;
            phase_d        = PH_IDLE;
          end else begin
            tick_d       = TICK_W'(1);
            phase_d      = PH_TRIG;
            flags_d.trig = 1'b1;
          end
        end else begin
          tick_d = tick_q + TICK_W'(1);
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
    flags_d.busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      sum_q   <= '0;
      shots_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      sum_q   <= sum_d;
      shots_q <= shots_d;
    end
  end

  // Stage 1: flags and the sum as it stands after this tick.
  tick_flags_t      s1_flags_q;
  logic [SUM_W-1:0] s1_sum_q;

  // Stage 2: reciprocal product.
  tick_flags_t      s2_flags_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic [P_W-1:0]   s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (ld1) s1_v_q <= in_acc;
      if (ld2) s2_v_q <= s1_v_q;
      if (ld3) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_flags_q <= flags_d;
      s1_sum_q   <= sum_d;
    end
    if (ld2) begin
      s2_flags_q <= s1_flags_q;
      s2_sum_q   <= s1_sum_q;
      s2_prod_q  <= P_W'(s1_sum_q) * P_W'(RECIP_M);
    end
  end

  // Stage 3: the reciprocal estimate may be one low; one compare fixes it.
  logic [Q_W-1:0]    q_est;
  logic [K-1:0]      numer;
  logic [K-1:0]      remain;
  logic [QX_W-1:0]   q_fix;
  logic [DIST_W-1:0] dist_new;

  always_comb begin
    q_est  = Q_W'(s2_prod_q >> (K - FRAC_BITS));
    numer  = {s2_sum_q, {FRAC_BITS{1'b0}}};
    remain = numer - K'(K'(q_est) * DIV_K);
    q_fix  = QX_W'(q_est) + QX_W'(remain >= DIV_K);
    if (q_fix > QX_W'(DIST_MAX)) begin
      dist_new = DIST_MAX;
    end else begin
      dist_new = q_fix[DIST_W-1:0];
    end
  end

  tick_flags_t       s3_flags_q;
  logic [DIST_W-1:0] last_dist_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_flags_q <= s2_flags_q;
    end
  end

  // The held distance only changes when a result beat enters the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dist_q <= '0;
    end else if (ld3 && s2_v_q && s2_flags_q.rvalid) begin
      last_dist_q <= dist_new;
    end
  end

  assign out_valid_o    = s3_v_q;
  assign trigger_out_o  = s3_flags_q.trig;
  assign busy_res_o     = s3_flags_q.busy;
  assign result_valid_o = s3_flags_q.rvalid;
  assign distance_q4_o  = last_dist_q;

endmodule

`default_nettype wire

// File: design/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks of the ultrasonic echo ranger, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ultrasonic_echo_ranger_unit_assert.svh"

module uer_checker
  import uer_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              trigger_out_o,
  input wire logic              busy_res_o,
  input wire logic              result_valid_o,
  input wire logic [DIST_W-1:0] distance_q4_o
);

  // A stalled beat stays and keeps its distance.
  `UER_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(distance_q4_o))

  // The result beat closes the sequence.
  `UER_ASSERT_NOW(a_result_not_busy, clk_i, rst_ni, out_valid_o && result_valid_o, !busy_res_o)

  // The trigger only fires inside a sequence.
  `UER_ASSERT_NOW(a_trig_busy, clk_i, rst_ni, out_valid_o && trigger_out_o, busy_res_o)

  // A shot and a result never share a beat.
  `UER_ASSERT_NOW(a_trig_no_result, clk_i, rst_ni, out_valid_o && trigger_out_o, !result_valid_o)

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .trigger_out_o  (trigger_out_o),
  .busy_res_o     (busy_res_o),
  .result_valid_o (result_valid_o),
  .distance_q4_o  (distance_q4_o)
);

`default_nettype wire
